### design/iew_pkg.sv
// shared widths, word codes, types and helper functions for the number-to-words block
`default_nettype none

package iew_pkg;

    // widths
    localparam int ValueW       = 32;
    localparam int DigitW       = 4;
    localparam int NumDigits    = 10;
    localparam int BcdW         = NumDigits * DigitW;
    localparam int CodeW        = 6;
    localparam int StageBits    = 8;
    localparam int NumBcdStages = ValueW / StageBits;
    localparam int NumSlots     = 18;

    typedef logic [CodeW-1:0]    t_code;
    typedef logic [DigitW-1:0]   t_digit;
    typedef logic [NumSlots-1:0] t_mask;

    // word codes
    localparam t_code CodeZero     = 6'd0;
    localparam t_code CodeTen      = 6'd10;
    localparam t_code CodeTwenty   = 6'd20;
    localparam t_code CodeHundred  = 6'd28;
    localparam t_code CodeThousand = 6'd29;
    localparam t_code CodeMillion  = 6'd30;
    localparam t_code CodeBillion  = 6'd31;
    localparam t_code CodeNegative = 6'd32;

    // candidate words of one item, earliest word in bit 0
    typedef struct packed {
        t_code [NumSlots-1:0] code;
        t_mask                en;
    } t_slots;

    // words of one three-digit group
    typedef struct packed {
        t_code hund_code;
        t_code tens_code;
        t_code unit_code;
        logic  hund_en;
        logic  tens_en;
        logic  unit_en;
        logic  nonzero;
    } t_group;

    // eight double-dabble steps: add-3 adjust then shift in one bit, msb first
    function automatic logic [BcdW-1:0] dd_steps(input logic [BcdW-1:0] bcd_in,
                                                 input logic [StageBits-1:0] bits);
        logic [BcdW-1:0] acc;
        acc = bcd_in;
        for (int s = StageBits - 1; s >= 0; s--) begin
            for (int d = 0; d < NumDigits; d++) begin
                if (acc[d*DigitW +: DigitW] >= 4'd5) begin
                    acc[d*DigitW +: DigitW] = acc[d*DigitW +: DigitW] + 4'd3;
                end
            end
            acc = {acc[BcdW-2:0], bits[s]};
        end
        return acc;
    endfunction

    // hundreds word, then tens or teen word, then units word
    function automatic t_group group_words(input t_digit h, input t_digit t, input t_digit u);
        t_group g;
        g.hund_code = {2'b00, h};
        g.hund_en   = (h != '0);
        g.unit_code = {2'b00, u};
        g.unit_en   = (t >= 4'd2) && (u != '0);
        g.tens_en   = (t != '0) || (u != '0);
        if (t >= 4'd2) begin
            g.tens_code = CodeTwenty + {2'b00, t} - 6'd2;
        end else if (t == 4'd1) begin
            g.tens_code = CodeTen + {2'b00, u};
        end else begin
            g.tens_code = {2'b00, u};
        end
        g.nonzero = g.hund_en || g.tens_en;
        return g;
    endfunction

endpackage

`default_nettype wire

### design/iew_bcd_stage.sv
// one pipeline stage of the binary to decimal conversion, eight bits per stage
`default_nettype none

module iew_bcd_stage (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_neg,
    input  wire  [iew_pkg::BcdW-1:0]       i_bcd,
    input  wire  [iew_pkg::ValueW-1:0]     i_bin,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic                           o_neg,
    output logic [iew_pkg::BcdW-1:0]       o_bcd,
    output logic [iew_pkg::ValueW-1:0]     o_bin
);

    logic                          r_valid;
    logic                          r_neg;
    logic [iew_pkg::BcdW-1:0]      r_bcd;
    logic [iew_pkg::ValueW-1:0]    r_bin;
    logic [iew_pkg::BcdW-1:0]      n_bcd;
    logic [iew_pkg::ValueW-1:0]    n_bin;
    logic                          load;

    // stage moves when empty or when downstream takes it
    assign load    = !r_valid || !i_stall;
    assign o_stall = r_valid && i_stall;

    // convert the top bits and shift them out
    always_comb begin
        n_bcd = iew_pkg::dd_steps(i_bcd,
                                  i_bin[iew_pkg::ValueW-1 -: iew_pkg::StageBits]);
        n_bin = {i_bin[iew_pkg::ValueW-iew_pkg::StageBits-1:0],
                 {iew_pkg::StageBits{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

`default_nettype wire

### design/iew_emit.sv
// word emitter: sends the enabled words of one item in order, one per cycle while the output is not stalled
`default_nettype none

module iew_emit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  iew_pkg::t_slots         i_slots,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [iew_pkg::CodeW-1:0]     o_word_code,
    output logic                          o_last_word
);

    logic                  r_e_valid;
    iew_pkg::t_slots       r_e_slots;
    logic                  r_out_valid;
    iew_pkg::t_code        r_word_code;
    logic                  r_last_word;
    iew_pkg::t_mask        lowest;
    iew_pkg::t_code        sel_code;
    logic                  is_last;
    logic                  out_free;
    logic                  emit;
    logic                  load;

    // pick the earliest remaining word
    always_comb begin
        lowest   = r_e_slots.en & (~r_e_slots.en + iew_pkg::t_mask'(1));
        sel_code = '0;
        for (int i = 0; i < iew_pkg::NumSlots; i++) begin
            if (lowest[i]) begin
                sel_code = sel_code | r_e_slots.code[i];
            end
        end
        is_last = ((r_e_slots.en & ~lowest) == '0);
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_e_valid && out_free;
    assign o_stall  = r_e_valid && !(emit && is_last);
    assign load     = i_valid && !o_stall;

    // item holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (load) begin
            r_e_valid <= 1'b1;
        end else if (emit && is_last) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_e_slots <= i_slots;
        end else if (emit) begin
            r_e_slots.en <= r_e_slots.en & ~lowest;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word_code <= sel_code;
            r_last_word <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_code = r_word_code;
    assign o_last_word = r_last_word;

    // a held item always has a word left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e_slots.en != '0))
        else $error("emitter holds an item with no words left");

    // exactly one word chosen per emit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> $onehot(lowest))
        else $error("emitter word select not one-hot");

    // emitted codes stay within the word list
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_word_code <= iew_pkg::CodeNegative))
        else $error("word code out of range");

    // a word leaves the holding register only into a free output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted word lost");

endmodule

`default_nettype wire

### design/integer_to_english_words_top.sv
// top level: spells a signed 32-bit integer as a sequence of English word codes
// A request carries one signed 32-bit value; the block answers with one result per word
// (1 to 17 words: "negative", digit, teen and tens words, hundred, thousand, million,
// billion), earliest word first, with o_last_word set on the final one. Requests enter a
// pipeline of registers (sign/magnitude, four binary-to-decimal stages of eight bits
// each, word selection, word emitter and its output register) and one can be taken
// every cycle while the pipe has room; the emitter then sends one word per cycle while
// the output is not stalled, and takes the next item only as it sends the final word of
// the item it holds. No reset pass.
`default_nettype none

module integer_to_english_words_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [31:0]                   i_value,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [5:0]                    o_word_code,
    output logic                          o_last_word
);

    localparam int N = iew_pkg::NumBcdStages;

    // slot positions in speaking order
    localparam int SlotNeg      = 0;
    localparam int SlotBDigit   = 1;
    localparam int SlotBillion  = 2;
    localparam int SlotMil      = 3;
    localparam int SlotThou     = 8;
    localparam int SlotUnits    = 13;
    localparam int SlotZero     = 17;

    logic                           r0_valid;
    logic                           r0_neg;
    logic [iew_pkg::ValueW-1:0]     r0_mag;
    logic                           load0;

    logic [N:0]                     c_valid;
    logic [N:0]                     c_stall;
    logic [N:0]                     c_neg;
    logic [N:0][iew_pkg::BcdW-1:0]  c_bcd;
    logic [N:0][iew_pkg::ValueW-1:0] c_bin;

    logic                           r5_valid;
    iew_pkg::t_slots                r5_slots;
    iew_pkg::t_slots                n5_slots;
    logic                           load5;
    logic                           e_stall;

    iew_pkg::t_digit [iew_pkg::NumDigits-1:0] dig;
    iew_pkg::t_group                gm;
    iew_pkg::t_group                gk;
    iew_pkg::t_group                gu;

    // sign and magnitude register
    assign load0      = !r0_valid || !c_stall[0];
    assign o_in_stall = r0_valid && c_stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (load0) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load0 && i_in_valid) begin
            r0_neg <= i_value[iew_pkg::ValueW-1];
            r0_mag <= i_value[iew_pkg::ValueW-1] ? (~i_value + 32'd1) : i_value;
        end
    end

    assign c_valid[0] = r0_valid;
    assign c_neg[0]   = r0_neg;
    assign c_bcd[0]   = '0;
    assign c_bin[0]   = r0_mag;

    // binary to decimal pipeline
    for (genvar k = 0; k < N; k++) begin : g_bcd
        iew_bcd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_stall (c_stall[k]),
            .i_neg   (c_neg[k]),
            .i_bcd   (c_bcd[k]),
            .i_bin   (c_bin[k]),
            .o_valid (c_valid[k+1]),
            .i_stall (c_stall[k+1]),
            .o_neg   (c_neg[k+1]),
            .o_bcd   (c_bcd[k+1]),
            .o_bin   (c_bin[k+1])
        );
    end

    // word selection from the decimal digits
    assign load5      = !r5_valid || !e_stall;
    assign c_stall[N] = r5_valid && e_stall;

    always_comb begin
        for (int d = 0; d < iew_pkg::NumDigits; d++) begin
            dig[d] = c_bcd[N][d*iew_pkg::DigitW +: iew_pkg::DigitW];
        end
        gm = iew_pkg::group_words(dig[8], dig[7], dig[6]);
        gk = iew_pkg::group_words(dig[5], dig[4], dig[3]);
        gu = iew_pkg::group_words(dig[2], dig[1], dig[0]);

        n5_slots = '0;
        n5_slots.code[SlotNeg]     = iew_pkg::CodeNegative;
        n5_slots.en[SlotNeg]       = c_neg[N];
        n5_slots.code[SlotBDigit]  = {2'b00, dig[9]};
        n5_slots.en[SlotBDigit]    = (dig[9] != '0);
        n5_slots.code[SlotBillion] = iew_pkg::CodeBillion;
        n5_slots.en[SlotBillion]   = (dig[9] != '0);

        n5_slots.code[SlotMil]     = gm.hund_code;
        n5_slots.en[SlotMil]       = gm.hund_en;
        n5_slots.code[SlotMil+1]   = iew_pkg::CodeHundred;
        n5_slots.en[SlotMil+1]     = gm.hund_en;
        n5_slots.code[SlotMil+2]   = gm.tens_code;
        n5_slots.en[SlotMil+2]     = gm.tens_en;
        n5_slots.code[SlotMil+3]   = gm.unit_code;
        n5_slots.en[SlotMil+3]     = gm.unit_en;
        n5_slots.code[SlotMil+4]   = iew_pkg::CodeMillion;
        n5_slots.en[SlotMil+4]     = gm.nonzero;

        n5_slots.code[SlotThou]    = gk.hund_code;
        n5_slots.en[SlotThou]      = gk.hund_en;
        n5_slots.code[SlotThou+1]  = iew_pkg::CodeHundred;
        n5_slots.en[SlotThou+1]    = gk.hund_en;
        n5_slots.code[SlotThou+2]  = gk.tens_code;
        n5_slots.en[SlotThou+2]    = gk.tens_en;
        n5_slots.code[SlotThou+3]  = gk.unit_code;
        n5_slots.en[SlotThou+3]    = gk.unit_en;
        n5_slots.code[SlotThou+4]  = iew_pkg::CodeThousand;
        n5_slots.en[SlotThou+4]    = gk.nonzero;

        n5_slots.code[SlotUnits]   = gu.hund_code;
        n5_slots.en[SlotUnits]     = gu.hund_en;
        n5_slots.code[SlotUnits+1] = iew_pkg::CodeHundred;
        n5_slots.en[SlotUnits+1]   = gu.hund_en;
        n5_slots.code[SlotUnits+2] = gu.tens_code;
        n5_slots.en[SlotUnits+2]   = gu.tens_en;
        n5_slots.code[SlotUnits+3] = gu.unit_code;
        n5_slots.en[SlotUnits+3]   = gu.unit_en;

        // whole value zero
        n5_slots.code[SlotZero]    = iew_pkg::CodeZero;
        n5_slots.en[SlotZero]      = (c_bcd[N] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (load5) begin
            r5_valid <= c_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load5 && c_valid[N]) begin
            r5_slots <= n5_slots;
        end
    end

    // word emitter and output register
    iew_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r5_valid),
        .o_stall     (e_stall),
        .i_slots     (r5_slots),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word)
    );

    // every value that reaches word selection has at least one word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid |-> (r5_slots.en != '0))
        else $error("item with no words");

    // a negative magnitude is never zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r0_valid && r0_neg |-> (r0_mag != '0))
        else $error("negative value with zero magnitude");

    // zero is spelled alone
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid && r5_slots.en[SlotZero] |-> $onehot(r5_slots.en))
        else $error("zero word combined with other words");

endmodule

`default_nettype wire
